### sv/spct_pkg.sv
package spct_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int TRIG_BITS_DEF  = 16;

  typedef enum logic [2:0] {
    CMD_CIRC_CIRC  = 3'd0,
    CMD_CIRC_BOX   = 3'd1,
    CMD_CIRC_RBOX  = 3'd2,
    CMD_BOX_BOX    = 3'd3,
    CMD_BOX_RBOX   = 3'd4,
    CMD_RBOX_RBOX  = 3'd5,
    CMD_UNUSED6    = 3'd6,
    CMD_UNUSED7    = 3'd7
  } cmd_t;

  // Quarter-wave sine table in Q1.14, index in whole degrees 0..90.
  function automatic logic [14:0] sin_q14(input logic [6:0] d);
    logic [14:0] v;
    begin
      unique case (d)
        7'd0: v = 15'd0;         7'd1: v = 15'd286;      7'd2: v = 15'd572;
        7'd3: v = 15'd857;       7'd4: v = 15'd1143;     7'd5: v = 15'd1428;
        7'd6: v = 15'd1713;      7'd7: v = 15'd1997;     7'd8: v = 15'd2280;
        7'd9: v = 15'd2563;      7'd10: v = 15'd2845;    7'd11: v = 15'd3126;
        7'd12: v = 15'd3406;     7'd13: v = 15'd3686;    7'd14: v = 15'd3964;
        7'd15: v = 15'd4240;     7'd16: v = 15'd4516;    7'd17: v = 15'd4790;
        7'd18: v = 15'd5063;     7'd19: v = 15'd5334;    7'd20: v = 15'd5604;
        7'd21: v = 15'd5872;     7'd22: v = 15'd6138;    7'd23: v = 15'd6402;
        7'd24: v = 15'd6664;     7'd25: v = 15'd6924;    7'd26: v = 15'd7182;
        7'd27: v = 15'd7438;     7'd28: v = 15'd7692;    7'd29: v = 15'd7943;
        7'd30: v = 15'd8192;     7'd31: v = 15'd8438;    7'd32: v = 15'd8682;
        7'd33: v = 15'd8923;     7'd34: v = 15'd9162;    7'd35: v = 15'd9397;
        7'd36: v = 15'd9630;     7'd37: v = 15'd9860;    7'd38: v = 15'd10087;
        7'd39: v = 15'd10311;    7'd40: v = 15'd10531;   7'd41: v = 15'd10749;
        7'd42: v = 15'd10963;    7'd43: v = 15'd11174;   7'd44: v = 15'd11381;
        7'd45: v = 15'd11585;    7'd46: v = 15'd11786;   7'd47: v = 15'd11982;
        7'd48: v = 15'd12176;    7'd49: v = 15'd12365;   7'd50: v = 15'd12551;
        7'd51: v = 15'd12733;    7'd52: v = 15'd12911;   7'd53: v = 15'd13085;
        7'd54: v = 15'd13255;    7'd55: v = 15'd13421;   7'd56: v = 15'd13583;
        7'd57: v = 15'd13741;    7'd58: v = 15'd13894;   7'd59: v = 15'd14044;
        7'd60: v = 15'd14189;    7'd61: v = 15'd14330;   7'd62: v = 15'd14466;
        7'd63: v = 15'd14598;    7'd64: v = 15'd14726;   7'd65: v = 15'd14849;
        7'd66: v = 15'd14968;    7'd67: v = 15'd15082;   7'd68: v = 15'd15191;
        7'd69: v = 15'd15296;    7'd70: v = 15'd15396;   7'd71: v = 15'd15491;
        7'd72: v = 15'd15582;    7'd73: v = 15'd15668;   7'd74: v = 15'd15749;
        7'd75: v = 15'd15826;    7'd76: v = 15'd15897;   7'd77: v = 15'd15964;
        7'd78: v = 15'd16026;    7'd79: v = 15'd16083;   7'd80: v = 15'd16135;
        7'd81: v = 15'd16182;    7'd82: v = 15'd16225;   7'd83: v = 15'd16262;
        7'd84: v = 15'd16294;    7'd85: v = 15'd16321;   7'd86: v = 15'd16343;
        7'd87: v = 15'd16361;    7'd88: v = 15'd16373;   7'd89: v = 15'd16382;
        7'd90: v = 15'd16384;
        default: v = 15'd0;
      endcase
      return v;
    end
  endfunction

  // Reduce 0..511 into 0..359.
  function automatic logic [8:0] wrap_deg(input logic [8:0] a);
    begin
      return (a >= 9'd360) ? 9'(a - 9'd360) : a;
    end
  endfunction

  // Signed Q1.14 sine of a whole degree 0..359.
  function automatic logic signed [15:0] sin_deg14(input logic [8:0] d);
    logic [14:0] m;
    logic        neg;
    begin
      neg = 1'b0;
      if (d <= 9'd90) begin
        m = sin_q14(d[6:0]);
      end else if (d <= 9'd180) begin
        m = sin_q14(7'(9'd180 - d));
      end else if (d <= 9'd270) begin
        m = sin_q14(7'(d - 9'd180));
        neg = 1'b1;
      end else begin
        m = sin_q14(7'(9'd360 - d));
        neg = 1'b1;
      end
      return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  endfunction

  function automatic logic [8:0] cos_arg(input logic [8:0] d);
    logic [9:0] t;
    begin
      t = {1'b0, d} + 10'd90;
      return (t >= 10'd360) ? 9'(t - 10'd360) : t[8:0];
    end
  endfunction

endpackage

### sv/spct_core.sv
// Datapath of the collision unit: a seven-stage pipeline with a shared
// advance enable. Every stage register carries a valid bit.
module spct_core
  import spct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TRIG_BITS  = TRIG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic [2:0]                   in_command,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_a_w,
  input  logic signed [COORD_BITS-1:0] in_a_h,
  input  logic [8:0]                   in_a_angle,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_b_w,
  input  logic signed [COORD_BITS-1:0] in_b_h,
  input  logic [8:0]                   in_b_angle,
  output logic                         res_valid,
  output logic                         res_hit
);

  localparam int F  = TRIG_BITS - 2;
  localparam int CW = COORD_BITS + 3;          // coordinate after sums/doubling
  localparam int TW = TRIG_BITS;               // signed trig width
  localparam int PW = CW + TW + 1;             // rotation products
  localparam int VW = CW + 2;                  // rotated points plus offsets
  localparam int JW = VW + TW + 2;             // projections
  localparam int SW = 2 * CW + 2;              // squared distances
  localparam int SH = (F >= 14) ? F - 14 : 14 - F;

  // Q1.14 to Q1.F, with round half up when F is below 14.
  function automatic logic signed [TW-1:0] tscale(input logic signed [15:0] q);
    logic signed [TW+15:0] t;
    begin
      if (F >= 14) begin
        t = (TW+16)'(q) <<< SH;
      end else begin
        t = ((TW+16)'(q) + ((TW+16)'(1) <<< (SH - 1))) >>> SH;
      end
      return t[TW-1:0];
    end
  endfunction

  function automatic logic signed [VW-1:0] rnd(input logic signed [PW:0] v);
    logic signed [PW:0] t;
    begin
      t = (v + ((PW+1)'(1) <<< (F - 1))) >>> F;
      return t[VW-1:0];
    end
  endfunction

  function automatic logic signed [CW-1:0] mn(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] mx(input logic signed [CW-1:0] a,
                                              input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] clampv(input logic signed [CW-1:0] v,
                                                  input logic signed [CW-1:0] lo,
                                                  input logic signed [CW-1:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [CW-1:0] absv(input logic signed [CW-1:0] v);
    return v[CW-1] ? CW'(-v) : CW'(v);
  endfunction

  // ---------------- stage 1: decode, differences, trig lookup ----------
  logic              v1_r;
  cmd_t              cmd1_r;
  logic signed [CW-1:0] bx0_1_r, by0_1_r, bx1_1_r, by1_1_r; // box a bounds
  logic signed [CW-1:0] dx1_r, dy1_r;      // frame offset to rotate
  logic signed [CW-1:0] ex1_r, ey1_r;      // offset added after rotating
  logic signed [CW-1:0] rad1_r, hx1_r, hy1_r;
  logic signed [CW-1:0] cbx1_r, cby1_r, cbw1_r, cbh1_r;
  logic signed [TW-1:0] fc1_r, fs1_r;      // frame rotation (cos, -sin)
  logic [8:0]           rang1_r;           // angle of the rotated box b

  logic [8:0] aang, bang, rang;
  logic [9:0] rsum;
  logic signed [CW-1:0] ax, ay, aw, ah, bx, by, bw, bh;
  logic signed [TW-1:0] fc_n, fs_n;

  always_comb begin
    ax = CW'(in_a_x); ay = CW'(in_a_y); aw = CW'(in_a_w); ah = CW'(in_a_h);
    bx = CW'(in_b_x); by = CW'(in_b_y); bw = CW'(in_b_w); bh = CW'(in_b_h);
    aang = wrap_deg(in_a_angle);
    bang = wrap_deg(in_b_angle);
    rsum = {1'b0, bang} + 10'd360 - {1'b0, aang};
    rang = (rsum >= 10'd360) ? 9'(rsum - 10'd360) : rsum[8:0];
    if (cmd_t'(in_command) == CMD_RBOX_RBOX) begin
      fc_n = tscale(sin_deg14(cos_arg(aang)));
      fs_n = -tscale(sin_deg14(aang));
    end else begin
      fc_n = tscale(sin_deg14(cos_arg(bang)));
      fs_n = -tscale(sin_deg14(bang));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r <= cmd_t'(in_command);
      fc1_r  <= fc_n;
      fs1_r  <= fs_n;
      rad1_r <= aw;
      cbx1_r <= bx; cby1_r <= by; cbw1_r <= bw; cbh1_r <= bh;
      hx1_r  <= bw; hy1_r <= bh;
      rang1_r <= (cmd_t'(in_command) == CMD_RBOX_RBOX) ? rang : bang;
      if (cmd_t'(in_command) == CMD_RBOX_RBOX) begin
        bx0_1_r <= mn('0, aw <<< 1); bx1_1_r <= mx('0, aw <<< 1);
        by0_1_r <= mn('0, ah <<< 1); by1_1_r <= mx('0, ah <<< 1);
        dx1_r <= bx - ax; dy1_r <= by - ay;
        ex1_r <= aw;      ey1_r <= ah;
      end else begin
        bx0_1_r <= mn(ax, ax + aw); bx1_1_r <= mx(ax, ax + aw);
        by0_1_r <= mn(ay, ay + ah); by1_1_r <= mx(ay, ay + ah);
        // Circle against rotated box: centre relative to the box centre.
        dx1_r <= ax - bx; dy1_r <= ay - by;
        ex1_r <= bw;      ey1_r <= bh;
      end
    end
  end

  // ---------------- stage 2: frame rotation products ----------------
  logic              v2_r;
  cmd_t              cmd2_r;
  logic signed [PW-1:0] pxc2_r, pys2_r, pxs2_r, pyc2_r;
  logic signed [CW-1:0] bx0_2_r, by0_2_r, bx1_2_r, by1_2_r, ex2_r, ey2_r;
  logic signed [CW-1:0] rad2_r, hx2_r, hy2_r, cbx2_r, cby2_r, cbw2_r, cbh2_r;
  logic signed [CW-1:0] dx2_r, dy2_r;
  logic signed [TW-1:0] bc2_r, bs2_r;
  logic signed [TW-1:0] bc_n, bs_n;

  always_comb begin
    bc_n = tscale(sin_deg14(cos_arg(rang1_r)));
    bs_n = tscale(sin_deg14(rang1_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r <= cmd1_r;
      pxc2_r <= PW'(dx1_r) * PW'(fc1_r);
      pys2_r <= PW'(dy1_r) * PW'(fs1_r);
      pxs2_r <= PW'(dx1_r) * PW'(fs1_r);
      pyc2_r <= PW'(dy1_r) * PW'(fc1_r);
      bx0_2_r <= bx0_1_r; by0_2_r <= by0_1_r; bx1_2_r <= bx1_1_r; by1_2_r <= by1_1_r;
      ex2_r <= ex1_r; ey2_r <= ey1_r;
      rad2_r <= rad1_r; hx2_r <= hx1_r; hy2_r <= hy1_r;
      cbx2_r <= cbx1_r; cby2_r <= cby1_r; cbw2_r <= cbw1_r; cbh2_r <= cbh1_r;
      dx2_r <= dx1_r; dy2_r <= dy1_r;
      bc2_r <= bc_n; bs2_r <= bs_n;
    end
  end

  // ---------------- stage 3: rounding, box b corner products -----------
  // Rotated corners of box b: (+-hx, +-hy) rotated by (c, s). Products of
  // hx and hy with c and s are formed here; signs are applied later.
  logic              v3_r;
  cmd_t              cmd3_r;
  logic signed [VW-1:0] lx3_r, ly3_r;          // local point after rounding
  logic signed [PW-1:0] hxc3_r, hyc3_r, hxs3_r, hys3_r;
  logic signed [CW-1:0] bx0_3_r, by0_3_r, bx1_3_r, by1_3_r, ex3_r, ey3_r;
  logic signed [CW-1:0] rad3_r, hx3_r, hy3_r, cbx3_r, cby3_r, cbw3_r, cbh3_r;
  logic signed [CW-1:0] dx3_r, dy3_r;
  logic signed [TW-1:0] bc3_r, bs3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3_r <= cmd2_r;
      lx3_r <= rnd((PW+1)'(pxc2_r) - (PW+1)'(pys2_r));
      ly3_r <= rnd((PW+1)'(pxs2_r) + (PW+1)'(pyc2_r));
      hxc3_r <= PW'(hx2_r) * PW'(bc2_r);
      hyc3_r <= PW'(hy2_r) * PW'(bc2_r);
      hxs3_r <= PW'(hx2_r) * PW'(bs2_r);
      hys3_r <= PW'(hy2_r) * PW'(bs2_r);
      bx0_3_r <= bx0_2_r; by0_3_r <= by0_2_r; bx1_3_r <= bx1_2_r; by1_3_r <= by1_2_r;
      ex3_r <= ex2_r; ey3_r <= ey2_r;
      rad3_r <= rad2_r; hx3_r <= hx2_r; hy3_r <= hy2_r;
      cbx3_r <= cbx2_r; cby3_r <= cby2_r; cbw3_r <= cbw2_r; cbh3_r <= cbh2_r;
      dx3_r <= dx2_r; dy3_r <= dy2_r;
      bc3_r <= bc2_r; bs3_r <= bs2_r;
    end
  end

  // ---------------- stage 4: corners of box b, circle clamp ------------
  logic              v4_r;
  cmd_t              cmd4_r;
  logic signed [VW-1:0] vx4_r [4];
  logic signed [VW-1:0] vy4_r [4];
  logic signed [CW-1:0] bx0_4_r, by0_4_r, bx1_4_r, by1_4_r;
  logic signed [TW-1:0] bc4_r, bs4_r;
  logic signed [CW-1:0] qx4_r, qy4_r, rad4_r;  // circle offset to nearest point
  logic                 bb4_r;                  // axis-aligned box test

  logic signed [VW-1:0] px_s, py_s;
  logic signed [VW-1:0] vx_n [4];
  logic signed [VW-1:0] vy_n [4];
  logic signed [CW-1:0] ccx, ccy, cx0, cx1, cy0, cy1, qx_n, qy_n;
  logic signed [CW-1:0] gx0, gx1, gy0, gy1;

  always_comb begin
    // Reference point of box b: world centre, or the shifted local centre.
    if (cmd3_r == CMD_RBOX_RBOX) begin
      px_s = lx3_r + VW'(ex3_r);
      py_s = ly3_r + VW'(ey3_r);
    end else begin
      px_s = VW'(cbx3_r);
      py_s = VW'(cby3_r);
    end
    for (int i = 0; i < 4; i++) begin
      logic signed [PW:0] xo, yo;
      xo = (i[0] ? (PW+1)'(hxc3_r) : -(PW+1)'(hxc3_r))
         - (i[1] ? (PW+1)'(hys3_r) : -(PW+1)'(hys3_r));
      yo = (i[0] ? (PW+1)'(hxs3_r) : -(PW+1)'(hxs3_r))
         + (i[1] ? (PW+1)'(hyc3_r) : -(PW+1)'(hyc3_r));
      vx_n[i] = px_s + rnd(xo);
      vy_n[i] = py_s + rnd(yo);
    end
    // Circle point and the box it is clamped onto.
    if (cmd3_r == CMD_CIRC_RBOX) begin
      ccx = CW'(lx3_r) + ex3_r;
      ccy = CW'(ly3_r) + ey3_r;
      cx0 = mn('0, ex3_r <<< 1); cx1 = mx('0, ex3_r <<< 1);
      cy0 = mn('0, ey3_r <<< 1); cy1 = mx('0, ey3_r <<< 1);
    end else begin
      ccx = cbx3_r + dx3_r;    // a_x
      ccy = cby3_r + dy3_r;    // a_y
      cx0 = mn(cbx3_r, cbx3_r + cbw3_r); cx1 = mx(cbx3_r, cbx3_r + cbw3_r);
      cy0 = mn(cby3_r, cby3_r + cbh3_r); cy1 = mx(cby3_r, cby3_r + cbh3_r);
    end
    if (cmd3_r == CMD_CIRC_CIRC) begin
      qx_n = -dx3_r;           // b - a
      qy_n = -dy3_r;
    end else begin
      qx_n = ccx - clampv(ccx, cx0, cx1);
      qy_n = ccy - clampv(ccy, cy0, cy1);
    end
    gx0 = mn(cbx3_r, cbx3_r + cbw3_r); gx1 = mx(cbx3_r, cbx3_r + cbw3_r);
    gy0 = mn(cby3_r, cby3_r + cbh3_r); gy1 = mx(cby3_r, cby3_r + cbh3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd4_r <= cmd3_r;
      vx4_r <= vx_n;
      vy4_r <= vy_n;
      bx0_4_r <= bx0_3_r; by0_4_r <= by0_3_r; bx1_4_r <= bx1_3_r; by1_4_r <= by1_3_r;
      bc4_r <= bc3_r; bs4_r <= bs3_r;
      qx4_r <= qx_n; qy4_r <= qy_n;
      rad4_r <= (cmd3_r == CMD_CIRC_CIRC) ? rad3_r + cbw3_r : rad3_r;
      bb4_r <= (gx0 <= bx1_3_r) && (bx0_3_r <= gx1) && (gy0 <= by1_3_r) && (by0_3_r <= gy1);
    end
  end

  // ---------------- stage 5: squares and edge-axis projections ---------
  // World axes need no multiply. Edge axes (c,s) and (-s,c) project each
  // point with two products; the box a corners use the same form.
  logic              v5_r;
  cmd_t              cmd5_r;
  logic [SW-1:0]     sqx5_r, sqy5_r, sqr5_r;
  logic              bb5_r;
  logic              w0_5_r, w1_5_r;            // world-axis overlaps
  logic signed [JW-1:0] pu5_r [8];              // axis u: 4 box a, 4 box b
  logic signed [JW-1:0] pv5_r [8];              // axis v

  logic signed [VW-1:0] cxv [4];
  logic signed [VW-1:0] cyv [4];
  logic signed [VW-1:0] vxmn, vxmx, vymn, vymx;

  always_comb begin
    cxv[0] = VW'(bx0_4_r); cyv[0] = VW'(by0_4_r);
    cxv[1] = VW'(bx0_4_r); cyv[1] = VW'(by1_4_r);
    cxv[2] = VW'(bx1_4_r); cyv[2] = VW'(by1_4_r);
    cxv[3] = VW'(bx1_4_r); cyv[3] = VW'(by0_4_r);
    vxmn = vx4_r[0]; vxmx = vx4_r[0]; vymn = vy4_r[0]; vymx = vy4_r[0];
    for (int i = 1; i < 4; i++) begin
      if (vx4_r[i] < vxmn) vxmn = vx4_r[i];
      if (vx4_r[i] > vxmx) vxmx = vx4_r[i];
      if (vy4_r[i] < vymn) vymn = vy4_r[i];
      if (vy4_r[i] > vymx) vymx = vy4_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (adv) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd5_r <= cmd4_r;
      sqx5_r <= SW'(absv(qx4_r)) * SW'(absv(qx4_r));
      sqy5_r <= SW'(absv(qy4_r)) * SW'(absv(qy4_r));
      sqr5_r <= SW'(absv(rad4_r)) * SW'(absv(rad4_r));
      bb5_r <= bb4_r;
      w0_5_r <= (vxmn <= VW'(bx1_4_r)) && (VW'(bx0_4_r) <= vxmx);
      w1_5_r <= (vymn <= VW'(by1_4_r)) && (VW'(by0_4_r) <= vymx);
      for (int i = 0; i < 4; i++) begin
        pu5_r[i]   <= JW'(bc4_r) * JW'(cxv[i]) + JW'(bs4_r) * JW'(cyv[i]);
        pv5_r[i]   <= JW'(bc4_r) * JW'(cyv[i]) - JW'(bs4_r) * JW'(cxv[i]);
        pu5_r[i+4] <= JW'(bc4_r) * JW'(vx4_r[i]) + JW'(bs4_r) * JW'(vy4_r[i]);
        pv5_r[i+4] <= JW'(bc4_r) * JW'(vy4_r[i]) - JW'(bs4_r) * JW'(vx4_r[i]);
      end
    end
  end

  // ---------------- stage 6: interval extents and distance sum --------
  logic              v6_r;
  cmd_t              cmd6_r;
  logic              dist6_r, bb6_r, w6_r;
  logic signed [JW-1:0] amnu6_r, amxu6_r, bmnu6_r, bmxu6_r;
  logic signed [JW-1:0] amnv6_r, amxv6_r, bmnv6_r, bmxv6_r;
  logic signed [JW-1:0] e_amnu, e_amxu, e_bmnu, e_bmxu, e_amnv, e_amxv, e_bmnv, e_bmxv;

  always_comb begin
    e_amnu = pu5_r[0]; e_amxu = pu5_r[0]; e_bmnu = pu5_r[4]; e_bmxu = pu5_r[4];
    e_amnv = pv5_r[0]; e_amxv = pv5_r[0]; e_bmnv = pv5_r[4]; e_bmxv = pv5_r[4];
    for (int i = 1; i < 4; i++) begin
      if (pu5_r[i] < e_amnu) e_amnu = pu5_r[i];
      if (pu5_r[i] > e_amxu) e_amxu = pu5_r[i];
      if (pu5_r[i+4] < e_bmnu) e_bmnu = pu5_r[i+4];
      if (pu5_r[i+4] > e_bmxu) e_bmxu = pu5_r[i+4];
      if (pv5_r[i] < e_amnv) e_amnv = pv5_r[i];
      if (pv5_r[i] > e_amxv) e_amxv = pv5_r[i];
      if (pv5_r[i+4] < e_bmnv) e_bmnv = pv5_r[i+4];
      if (pv5_r[i+4] > e_bmxv) e_bmxv = pv5_r[i+4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (adv) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd6_r  <= cmd5_r;
      dist6_r <= ((SW+1)'(sqx5_r) + (SW+1)'(sqy5_r)) <= (SW+1)'(sqr5_r);
      bb6_r   <= bb5_r;
      w6_r    <= w0_5_r && w1_5_r;
      amnu6_r <= e_amnu; amxu6_r <= e_amxu; bmnu6_r <= e_bmnu; bmxu6_r <= e_bmxu;
      amnv6_r <= e_amnv; amxv6_r <= e_amxv; bmnv6_r <= e_bmnv; bmxv6_r <= e_bmxv;
    end
  end

  // ---------------- stage 7: overlap decision --------------------------
  logic v7_r, hit7_r, hit_nxt, sat;

  always_comb begin
    sat = w6_r && (bmnu6_r <= amxu6_r) && (amnu6_r <= bmxu6_r)
              && (bmnv6_r <= amxv6_r) && (amnv6_r <= bmxv6_r);
    unique case (cmd6_r)
      CMD_CIRC_CIRC, CMD_CIRC_BOX, CMD_CIRC_RBOX: hit_nxt = dist6_r;
      CMD_BOX_BOX:                                hit_nxt = bb6_r;
      CMD_BOX_RBOX, CMD_RBOX_RBOX:                hit_nxt = sat;
      default:                                    hit_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (adv) begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit7_r <= hit_nxt;
    end
  end

  assign res_valid = v7_r;
  assign res_hit   = hit7_r;

endmodule

### sv/shape_pair_collision_test_2d_unit.sv
// Overlap test for one pair of 2D shapes per word: circles, axis-aligned
// boxes and rotated boxes in signed Q16.8, with whole-degree rotations. The
// unit is a seven-stage pipeline that accepts one word every clock while the
// output does not stall and returns one hit word per input word, in order.
// The depth is set by the chain of trig lookup, frame rotation, rounding,
// corner rotation, projection onto the separating axes, interval extents
// and the final compare. A stall on the output holds the whole pipeline;
// in_ready follows out_ready or an empty output slot, so no word is lost or
// repeated. Commands 6 and 7 return 0.
module shape_pair_collision_test_2d_unit
  import spct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TRIG_BITS  = TRIG_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   in_command,
  input  logic signed [COORD_BITS-1:0] in_a_x,
  input  logic signed [COORD_BITS-1:0] in_a_y,
  input  logic signed [COORD_BITS-1:0] in_a_w,
  input  logic signed [COORD_BITS-1:0] in_a_h,
  input  logic [8:0]                   in_a_angle,
  input  logic signed [COORD_BITS-1:0] in_b_x,
  input  logic signed [COORD_BITS-1:0] in_b_y,
  input  logic signed [COORD_BITS-1:0] in_b_w,
  input  logic signed [COORD_BITS-1:0] in_b_h,
  input  logic [8:0]                   in_b_angle,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);

  logic adv;

  // The last stage register is the output register; everything moves when it
  // is empty or being taken.
  assign adv      = out_ready || !out_valid;
  assign in_ready = adv;

  spct_core #(
    .COORD_BITS(COORD_BITS),
    .TRIG_BITS (TRIG_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_a_x    (in_a_x),
    .in_a_y    (in_a_y),
    .in_a_w    (in_a_w),
    .in_a_h    (in_a_h),
    .in_a_angle(in_a_angle),
    .in_b_x    (in_b_x),
    .in_b_y    (in_b_y),
    .in_b_w    (in_b_w),
    .in_b_h    (in_b_h),
    .in_b_angle(in_b_angle),
    .res_valid (out_valid),
    .res_hit   (out_hit)
  );

endmodule

### sv/spct_checker.sv
// Port-level checks of the collision unit.
module spct_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // Output word holds while stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("stalled output word changed");

  // Input is taken whenever the output side is free.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input refused while output free");

  // A stalled output blocks the input.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken during output stall");

  // Output is empty right after reset.
  assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind shape_pair_collision_test_2d_unit spct_checker u_spct_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_hit  (out_hit)
);

### test/shape_pair_collision_test_2d_unit_test.sv
module shape_pair_collision_test_2d_unit_test;
  import spct_pkg::*;

  localparam int CW = COORD_BITS_DEF;

  // One shape pair as it travels through the input channel.
  typedef struct {
    cmd_t                cmd;
    logic signed [CW-1:0] ax, ay, aw, ah;
    logic [8:0]           aang;
    logic signed [CW-1:0] bx, by, bw, bh;
    logic [8:0]           bang;
  } pair_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [2:0] in_command;
  logic signed [CW-1:0] in_a_x, in_a_y, in_a_w, in_a_h;
  logic [8:0] in_a_angle;
  logic signed [CW-1:0] in_b_x, in_b_y, in_b_w, in_b_h;
  logic [8:0] in_b_angle;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_hit;

  // Hit bits predicted for accepted words, oldest first.
  logic pending_hits[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stuck_cycles = 0;

  // Whole-degree sine table in Q1.14 for the first quadrant.
  int sine_tab[91] = '{
    0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
    2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
    5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
    8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16321, 16343, 16361, 16373, 16382,
    16384};

  shape_pair_collision_test_2d_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_w(in_a_w), .in_a_h(in_a_h),
    .in_a_angle(in_a_angle),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_w(in_b_w), .in_b_h(in_b_h),
    .in_b_angle(in_b_angle),
    .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor. The trig fraction is 14 bits at the default TRIG_BITS, so
  // the table is used unscaled. Products of 24-bit coordinates and Q1.14
  // trig fit the 64-bit arithmetic; squared distances use 128 bits.
  // ---------------------------------------------------------------------

  // Angles of 360 and up fold back once into 0..359.
  function automatic int fold_angle(logic [8:0] a);
    return (a >= 9'd360) ? int'(a) - 360 : int'(a);
  endfunction

  function automatic longint sine_of(int d);
    if (d <= 90) return longint'(sine_tab[d]);
    else if (d <= 180) return longint'(sine_tab[180 - d]);
    else if (d <= 270) return -longint'(sine_tab[d - 180]);
    else return -longint'(sine_tab[(360 - d) % 91]);
  endfunction

  function automatic longint cosine_of(int d);
    return sine_of((d + 90) % 360);
  endfunction

  // Round half up while dropping the 14 trig fraction bits.
  function automatic longint drop_trig(longint v);
    return (v + 64'sd8192) >>> 14;
  endfunction

  function automatic void turn(longint x, longint y, longint c, longint s,
                               output longint ox, output longint oy);
    ox = drop_trig(x * c - y * s);
    oy = drop_trig(x * s + y * c);
  endfunction

  // Exact squared-distance test; only the square of the radius matters.
  function automatic logic near_enough(longint dx, longint dy, longint r);
    logic signed [127:0] d2, r2;
    d2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
    r2 = 128'(r) * 128'(r);
    return d2 <= r2;
  endfunction

  function automatic longint lo2(longint a, longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic longint hi2(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // Clamp the centre onto the box; a negative size spans the other way.
  function automatic logic circle_vs_box(longint cx, longint cy, longint r,
                                         longint bx, longint by,
                                         longint bw, longint bh);
    longint x0, x1, y0, y1, px, py;
    x0 = lo2(bx, bx + bw);
    x1 = hi2(bx, bx + bw);
    y0 = lo2(by, by + bh);
    y1 = hi2(by, by + bh);
    px = (cx < x0) ? x0 : ((cx > x1) ? x1 : cx);
    py = (cy < y0) ? y0 : ((cy > y1) ? y1 : cy);
    return near_enough(cx - px, cy - py, r);
  endfunction

  // Separating-axis test of bounds (x0,y0)-(x1,y1) against a rotated box
  // with centre (px,py), half extents (hx,hy) and angle ang.
  function automatic logic bounds_vs_rotated(longint x0, longint y0,
                                             longint x1, longint y1,
                                             longint px, longint py,
                                             longint hx, longint hy, int ang);
    longint c, s, ox, oy, pa, pb, amin, amax, bmin, bmax;
    longint axx[4], axy[4], cx[4], cy[4], vx[4], vy[4];
    c = cosine_of(ang);
    s = sine_of(ang);
    axx = '{64'sd16384, 0, c, -s};
    axy = '{0, 64'sd16384, s, c};
    cx = '{x0, x0, x1, x1};
    cy = '{y0, y1, y1, y0};
    for (int i = 0; i < 4; i++) begin
      turn((i & 1) ? hx : -hx, (i & 2) ? hy : -hy, c, s, ox, oy);
      vx[i] = px + ox;
      vy[i] = py + oy;
    end
    for (int k = 0; k < 4; k++) begin
      amin = 0; amax = 0; bmin = 0; bmax = 0;
      for (int i = 0; i < 4; i++) begin
        pa = axx[k] * cx[i] + axy[k] * cy[i];
        pb = axx[k] * vx[i] + axy[k] * vy[i];
        if (i == 0 || pa < amin) amin = pa;
        if (i == 0 || pa > amax) amax = pa;
        if (i == 0 || pb < bmin) bmin = pb;
        if (i == 0 || pb > bmax) bmax = pb;
      end
      if (!(bmin <= amax && amin <= bmax)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic predict_hit(pair_t p);
    longint ax, ay, aw, ah, bx, by, bw, bh, lx, ly;
    int aa, ba;
    ax = longint'(p.ax); ay = longint'(p.ay); aw = longint'(p.aw); ah = longint'(p.ah);
    bx = longint'(p.bx); by = longint'(p.by); bw = longint'(p.bw); bh = longint'(p.bh);
    aa = fold_angle(p.aang);
    ba = fold_angle(p.bang);
    case (p.cmd)
      CMD_CIRC_CIRC: return near_enough(bx - ax, by - ay, aw + bw);
      CMD_CIRC_BOX:  return circle_vs_box(ax, ay, aw, bx, by, bw, bh);
      CMD_CIRC_RBOX: begin
        // Move the circle into the box frame, corner at the origin.
        turn(ax - bx, ay - by, cosine_of(ba), -sine_of(ba), lx, ly);
        return circle_vs_box(lx + bw, ly + bh, aw, 0, 0, 2 * bw, 2 * bh);
      end
      CMD_BOX_BOX:
        return lo2(bx, bx + bw) <= hi2(ax, ax + aw) && lo2(ax, ax + aw) <= hi2(bx, bx + bw)
            && lo2(by, by + bh) <= hi2(ay, ay + ah) && lo2(ay, ay + ah) <= hi2(by, by + bh);
      CMD_BOX_RBOX:
        return bounds_vs_rotated(lo2(ax, ax + aw), lo2(ay, ay + ah),
                                 hi2(ax, ax + aw), hi2(ay, ay + ah),
                                 bx, by, bw, bh, ba);
      CMD_RBOX_RBOX: begin
        // Shape a becomes an axis-aligned box at the origin; b follows.
        turn(bx - ax, by - ay, cosine_of(aa), -sine_of(aa), lx, ly);
        return bounds_vs_rotated(lo2(0, 2 * aw), lo2(0, 2 * ah),
                                 hi2(0, 2 * aw), hi2(0, 2 * ah),
                                 lx + aw, ly + ah, bw, bh, (ba + 360 - aa) % 360);
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Channel monitors. Both sample pre-edge values at the rising edge.
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    pair_t p;
    if (rst_n && in_valid && in_ready) begin
      p.cmd = cmd_t'(in_command);
      p.ax = in_a_x; p.ay = in_a_y; p.aw = in_a_w; p.ah = in_a_h;
      p.aang = in_a_angle;
      p.bx = in_b_x; p.by = in_b_y; p.bw = in_b_w; p.bh = in_b_h;
      p.bang = in_b_angle;
      pending_hits.push_back(predict_hit(p));
    end
  end

  // Each hit word is compared against the oldest prediction.
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected hit word, expected none, actual %b", $time, out_hit);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (out_hit !== want) begin
          $display("%0t: hit mismatch, expected %b, actual %b", $time, want, out_hit);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at random with the current idle percentage.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // The watchdog only counts while work is outstanding and nothing moves.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (!in_valid && pending_hits.size() == 0)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= 4000) begin
      $display("shape_pair_collision_test_2d_unit verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------

  // Sends one word, with an optional random gap first. Valid is left high
  // so that back-to-back words keep the channel busy.
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= p.cmd;
    in_a_x <= p.ax; in_a_y <= p.ay; in_a_w <= p.aw; in_a_h <= p.ah;
    in_a_angle <= p.aang;
    in_b_x <= p.bx; in_b_y <= p.by; in_b_w <= p.bw; in_b_h <= p.bh;
    in_b_angle <= p.bang;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops sending and waits until every predicted word has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  function automatic pair_t make_pair(cmd_t c, int ax, int ay, int aw, int ah, int aang,
                                      int bx, int by, int bw, int bh, int bang);
    pair_t p;
    p.cmd = c;
    p.ax = CW'(ax); p.ay = CW'(ay); p.aw = CW'(aw); p.ah = CW'(ah); p.aang = 9'(aang);
    p.bx = CW'(bx); p.by = CW'(by); p.bw = CW'(bw); p.bh = CW'(bh); p.bang = 9'(bang);
    return p;
  endfunction

  // Mostly coordinates in a narrow window so that shapes often meet, and
  // now and then a full-range value so that every bit toggles.
  function automatic logic signed [CW-1:0] pick_coord(int span);
    if ($urandom_range(9) == 0) return CW'($urandom);
    return CW'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [CW-1:0] pick_size(int span);
    if ($urandom_range(9) == 0) return CW'($urandom);
    if ($urandom_range(7) == 0) return CW'(-$signed($urandom_range(0, span)));
    return CW'($urandom_range(0, span));
  endfunction

  function automatic logic [8:0] pick_angle();
    if ($urandom_range(7) == 0) return 9'($urandom_range(360, 511));
    return 9'($urandom_range(0, 359));
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int span, ox, oy;
    span = 1 << $urandom_range(6, 14);
    // Unused commands show up only rarely.
    p.cmd = ($urandom_range(29) == 0) ? cmd_t'($urandom_range(6, 7))
                                       : cmd_t'($urandom_range(0, 5));
    ox = int'(pick_coord(1 << 20));
    oy = int'(pick_coord(1 << 20));
    p.ax = CW'(ox + int'(pick_coord(span))); p.ay = CW'(oy + int'(pick_coord(span)));
    p.bx = CW'(ox + int'(pick_coord(span))); p.by = CW'(oy + int'(pick_coord(span)));
    p.aw = pick_size(span); p.ah = pick_size(span);
    p.bw = pick_size(span); p.bh = pick_size(span);
    p.aang = pick_angle();
    p.bang = pick_angle();
    return p;
  endfunction

  // Field extremes, every command and each corner case named by the design.
  task automatic test_directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    // Circles that just touch, then just miss.
    send_pair(make_pair(CMD_CIRC_CIRC, 0, 0, 256, 0, 0, 768, 0, 512, 0, 0));
    send_pair(make_pair(CMD_CIRC_CIRC, 0, 0, 256, 0, 0, 769, 0, 512, 0, 0));
    // Negative radius only counts through its square.
    send_pair(make_pair(CMD_CIRC_CIRC, 0, 0, -1024, 0, 0, 300, 300, -20, 0, 0));
    // Coordinate extremes at both ends.
    send_pair(make_pair(CMD_CIRC_CIRC, mn, mn, mx, mx, 511, mx, mx, mx, mx, 511));
    send_pair(make_pair(CMD_BOX_BOX, mn, mn, mx, mx, 0, mx, mx, mn, mn, 0));
    send_pair(make_pair(CMD_CIRC_BOX, mx, mn, mx, mn, 0, mn, mx, mn, mx, 0));
    // Circle against a box with negative width and height.
    send_pair(make_pair(CMD_CIRC_BOX, -100, -100, 50, 0, 0, 0, 0, -1000, -1000, 0));
    send_pair(make_pair(CMD_CIRC_BOX, 2000, 2000, 100, 0, 0, 0, 0, 1000, 1000, 0));
    // Boxes touching on an edge, and apart.
    send_pair(make_pair(CMD_BOX_BOX, 0, 0, 512, 512, 0, 512, 0, 256, 256, 0));
    send_pair(make_pair(CMD_BOX_BOX, 0, 0, 512, 512, 0, 513, 0, 256, 256, 0));
    // Circle against a rotated box, including a wrapped angle.
    send_pair(make_pair(CMD_CIRC_RBOX, 700, 0, 100, 0, 0, 0, 0, 512, 64, 45));
    send_pair(make_pair(CMD_CIRC_RBOX, 0, 700, 100, 0, 0, 0, 0, 512, 64, 405));
    send_pair(make_pair(CMD_CIRC_RBOX, mx, mn, mn, mx, 0, mn, mx, mx, mn, 359));
    // Zero half extents still use the unit edge axes.
    send_pair(make_pair(CMD_BOX_RBOX, 0, 0, 256, 256, 0, 128, 128, 0, 0, 30));
    send_pair(make_pair(CMD_BOX_RBOX, 0, 0, -256, -256, 0, 600, 600, 300, 100, 315));
    send_pair(make_pair(CMD_BOX_RBOX, mn, mx, mx, mn, 0, mx, mn, mn, mx, 511));
    // Relative angle wraps when a is turned further than b.
    send_pair(make_pair(CMD_RBOX_RBOX, 0, 0, 512, 128, 300, 700, 0, 512, 128, 10));
    send_pair(make_pair(CMD_RBOX_RBOX, 0, 0, 512, 128, 90, 0, 800, 512, 128, 450));
    send_pair(make_pair(CMD_RBOX_RBOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(CMD_RBOX_RBOX, mx, mx, mn, mn, 511, mn, mn, mx, mx, 360));
    // Unused commands give no hit even for overlapping shapes.
    send_pair(make_pair(CMD_UNUSED6, 0, 0, 512, 512, 0, 0, 0, 512, 512, 0));
    send_pair(make_pair(CMD_UNUSED7, 0, 0, 512, 512, 0, 0, 0, 512, 512, 0));
    drain_results();
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) begin
      send_pair(random_pair());
      // Hold the sender once per phase until everything is back.
      if (i == count / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_command <= CMD_CIRC_CIRC;
    in_a_x <= '0; in_a_y <= '0; in_a_w <= '0; in_a_h <= '0; in_a_angle <= '0;
    in_b_x <= '0; in_b_y <= '0; in_b_w <= '0; in_b_h <= '0; in_b_angle <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(600, 28, 82);
    test_random(600, 82, 28);
    test_random(600, 0, 0);

    // Let the pipeline settle so that a stray extra word would show up.
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("shape_pair_collision_test_2d_unit verification clean");
    end else begin
      $display("shape_pair_collision_test_2d_unit verification failed");
    end
    $finish;
  end

endmodule
